// ===== rtl/note_text_to_tone_sequencer_macros.svh =====
// ----------------------------------------------------------------------------
// Note text to tone sequencer: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NOTE_TEXT_TO_TONE_SEQUENCER_MACROS_SVH
`define NOTE_TEXT_TO_TONE_SEQUENCER_MACROS_SVH

// same-cycle implication
`define NTTSEQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NTTSEQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/nttseq_pkg.sv =====
// ----------------------------------------------------------------------------
// nttseq_pkg
// Types, constants and lookup functions of the note text to tone sequencer.
// ----------------------------------------------------------------------------
package nttseq_pkg;

    localparam int TOKEN_CHARS = 8;
    localparam int LEN_W       = $clog2(TOKEN_CHARS + 1);
    localparam int IDX_W       = $clog2(TOKEN_CHARS);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int FREQ_W = 13;
    localparam int DUR_W  = 14;
    localparam int KEY_W  = 7;
    localparam int MS_W   = 12;
    localparam int OCT_W  = 6;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_MS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_MS        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_UNIT_MS = 2'd2;

    localparam logic [MS_W-1:0] TONE_MS_RST       = 12'd500;
    localparam logic [MS_W-1:0] GAP_MS_RST        = 12'd50;
    localparam logic [MS_W-1:0] PAUSE_UNIT_MS_RST = 12'd250;

    localparam logic signed [OCT_W-1:0] OCT_MAX = 6'sb011111;
    localparam logic signed [OCT_W-1:0] OCT_MIN = 6'sb100000;
    localparam logic signed [OCT_W-1:0] OCT_TOP = 6'sd8;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_NOTE,
        CMD_PAUSE,
        CMD_ERROR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic             term;
        logic [KEY_W-1:0] key;
        logic [1:0]       pause_shift;
    } cmd_t;

    typedef struct packed {
        logic [MS_W-1:0] tone_ms;
        logic [MS_W-1:0] gap_ms;
        logic [MS_W-1:0] pause_unit_ms;
    } cfg_t;

    typedef struct packed {
        logic              is_last;
        logic              is_error;
        logic [KEY_W-1:0]  key_number;
        logic [DUR_W-1:0]  duration_ms;
        logic [FREQ_W-1:0] freq_hz;
    } result_t;

    localparam int NUM_KEYS = 88;

    localparam logic [FREQ_W-1:0] KEY_FREQ [NUM_KEYS] = '{
        13'd28,   13'd29,   13'd31,   13'd33,   13'd35,   13'd37,
        13'd39,   13'd41,   13'd44,   13'd46,   13'd49,   13'd52,
        13'd55,   13'd58,   13'd62,   13'd65,   13'd69,   13'd73,
        13'd78,   13'd82,   13'd87,   13'd92,   13'd98,   13'd104,
        13'd110,  13'd117,  13'd123,  13'd131,  13'd139,  13'd147,
        13'd156,  13'd165,  13'd175,  13'd185,  13'd196,  13'd208,
        13'd220,  13'd233,  13'd247,  13'd262,  13'd277,  13'd294,
        13'd311,  13'd330,  13'd349,  13'd370,  13'd392,  13'd415,
        13'd440,  13'd466,  13'd494,  13'd523,  13'd554,  13'd587,
        13'd622,  13'd659,  13'd698,  13'd740,  13'd784,  13'd831,
        13'd880,  13'd932,  13'd988,  13'd1047, 13'd1109, 13'd1175,
        13'd1245, 13'd1319, 13'd1397, 13'd1480, 13'd1568, 13'd1661,
        13'd1760, 13'd1865, 13'd1976, 13'd2093, 13'd2217, 13'd2349,
        13'd2489, 13'd2637, 13'd2794, 13'd2960, 13'd3136, 13'd3322,
        13'd3520, 13'd3729, 13'd3951, 13'd4186
    };

    // key 1..88 to frequency, 0 off the keyboard
    function automatic logic [FREQ_W-1:0] key_freq(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] idx;
        idx = key - 7'd1;
        if (key != '0 && idx < KEY_W'(NUM_KEYS))
            return KEY_FREQ[idx];
        return '0;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
            return c + 8'd32;
        return c;
    endfunction

    // semitone above C of letters A..G
    function automatic logic [3:0] letter_semi(input logic [2:0] letter);
        logic [3:0] semi;
        case (letter)
            3'd0:    semi = 4'd9;
            3'd1:    semi = 4'd11;
            3'd2:    semi = 4'd0;
            3'd3:    semi = 4'd2;
            3'd4:    semi = 4'd4;
            3'd5:    semi = 4'd5;
            3'd6:    semi = 4'd7;
            default: semi = 4'd0;
        endcase
        return semi;
    endfunction

endpackage

// ===== rtl/nttseq_front.sv =====
// ----------------------------------------------------------------------------
// nttseq_front
// Collects text bytes into tokens, tracks the octave and turns each finished
// note, pause or bad token into one command for the back end.
// ----------------------------------------------------------------------------
module nttseq_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      char_code,
    input  logic                            end_of_text,
    input  logic [3:0]                      start_octave,
    input  logic                            queue_full,
    output logic                            push,
    output nttseq_pkg::cmd_t                cmd
);
    import nttseq_pkg::*;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_8     = 8'h38;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UG    = 8'h47;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_W     = 8'h77;

    logic [7:0]              chars_reg [TOKEN_CHARS];
    logic [LEN_W-1:0]        len_reg, len_next;
    logic                    ovf_reg, ovf_next;
    logic signed [OCT_W-1:0] oct_reg, oct_next;
    logic                    skip_reg, skip_next;
    logic                    start_reg, start_next;

    logic                    fire;
    logic [LEN_W-1:0]        eff_len;
    logic                    eff_ovf;
    logic signed [OCT_W-1:0] eff_oct;
    logic                    eff_skip;
    logic                    is_space;
    logic                    char_wr;

    logic [7:0]              c0, c1, c2, c3, c4, c5;
    logic [7:0]              l0, l1, l2, l3, l4;
    logic                    tok_empty;
    logic                    is_up, is_down, is_digit, is_pause, oct_ok;
    logic                    sol_hit, let_hit, let_shape_ok;
    logic [2:0]              sol_letter, note_letter;
    logic [3:0]              note_oct;
    logic [KEY_W-1:0]        key_raw;
    logic                    key_ok;
    logic                    cls_bad;
    cmd_t                    cls_cmd;
    logic signed [OCT_W-1:0] cls_oct;

    assign in_ready = !queue_full;
    assign fire     = in_valid && in_ready;

    assign eff_len  = start_reg ? '0 : len_reg;
    assign eff_ovf  = start_reg ? 1'b0 : ovf_reg;
    assign eff_oct  = start_reg ? $signed({2'b00, start_octave}) : oct_reg;
    assign eff_skip = start_reg ? 1'b0 : skip_reg;
    assign is_space = (char_code == CH_SPACE);

    assign c0 = chars_reg[0];
    assign c1 = chars_reg[1];
    assign c2 = chars_reg[2];
    assign c3 = chars_reg[3];
    assign c4 = chars_reg[4];
    assign c5 = chars_reg[5];
    assign l0 = to_lower(c0);
    assign l1 = to_lower(c1);
    assign l2 = to_lower(c2);
    assign l3 = to_lower(c3);
    assign l4 = to_lower(c4);

    // token classifier
    always_comb
    begin
        tok_empty = (eff_len == '0) && !eff_ovf;
        is_up     = (eff_len == LEN_W'(2)) && l0 == CH_U && l1 == CH_P;
        is_down   = (eff_len == LEN_W'(4)) && l0 == CH_D && l1 == CH_O
                    && l2 == CH_W && l3 == CH_N;
        is_digit  = (eff_len == LEN_W'(1)) && c0 >= CH_0 && c0 <= CH_8;
        is_pause  = (eff_len == LEN_W'(6)) && l0 == CH_P && l1 == CH_A
                    && l2 == CH_U && l3 == CH_S && l4 == CH_E
                    && (c5 == CH_1 || c5 == CH_2 || c5 == CH_4);
        oct_ok    = (eff_oct >= 0) && (eff_oct <= OCT_TOP);

        sol_hit    = 1'b1;
        sol_letter = 3'd0;
        if (eff_len == LEN_W'(2) && l0 == CH_D && l1 == CH_O)
            sol_letter = 3'd2;
        else if (eff_len == LEN_W'(2) && l0 == CH_R && l1 == CH_E)
            sol_letter = 3'd3;
        else if (eff_len == LEN_W'(2) && l0 == CH_M && l1 == CH_I)
            sol_letter = 3'd4;
        else if (eff_len == LEN_W'(2) && l0 == CH_F && l1 == CH_A)
            sol_letter = 3'd5;
        else if (eff_len == LEN_W'(3) && l0 == CH_S && l1 == CH_O && l2 == CH_L)
            sol_letter = 3'd6;
        else if (eff_len == LEN_W'(2) && l0 == CH_L && l1 == CH_A)
            sol_letter = 3'd0;
        else if (eff_len == LEN_W'(2) && l0 == CH_T && l1 == CH_I)
            sol_letter = 3'd1;
        else
            sol_hit = 1'b0;

        let_hit      = (c0 >= CH_UA) && (c0 <= CH_UG);
        let_shape_ok = (eff_len == LEN_W'(1))
                       || ((eff_len == LEN_W'(2)) && c1 >= CH_0 && c1 <= CH_8);

        note_letter = sol_hit ? sol_letter : 3'(c0 - CH_UA);
        if (!sol_hit && eff_len == LEN_W'(2))
            note_oct = c1[3:0];
        else
            note_oct = eff_oct[3:0];

        key_raw = 7'({note_oct, 3'b000}) + 7'({note_oct, 2'b00})
                  + 7'(letter_semi(note_letter));
        key_ok  = (key_raw >= 7'd9) && (key_raw <= 7'd96);

        cls_bad              = 1'b0;
        cls_oct              = eff_oct;
        cls_cmd.kind         = CMD_NONE;
        cls_cmd.term         = 1'b0;
        cls_cmd.key          = key_raw - 7'd8;
        cls_cmd.pause_shift  = (c5 == CH_1) ? 2'd0 : (c5 == CH_2) ? 2'd1 : 2'd2;

        if (tok_empty)
            cls_bad = 1'b0;
        else if (eff_ovf)
            cls_bad = 1'b1;
        else if (is_up)
            cls_oct = (eff_oct != OCT_MAX) ? eff_oct + 6'sd1 : eff_oct;
        else if (is_down)
            cls_oct = (eff_oct != OCT_MIN) ? eff_oct - 6'sd1 : eff_oct;
        else if (is_digit)
            cls_oct = $signed({2'b00, c0[3:0]});
        else if (!oct_ok)
            cls_bad = 1'b1;
        else if (is_pause)
            cls_cmd.kind = CMD_PAUSE;
        else if ((sol_hit || (let_hit && let_shape_ok)) && key_ok)
            cls_cmd.kind = CMD_NOTE;
        else
            cls_bad = 1'b1;

        if (cls_bad)
            cls_cmd.kind = CMD_ERROR;
    end

    always_comb
    begin
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        oct_next   = oct_reg;
        skip_next  = skip_reg;
        start_next = start_reg;
        push       = 1'b0;
        cmd        = cls_cmd;
        char_wr    = 1'b0;
        if (fire)
        begin
            len_next   = eff_len;
            ovf_next   = eff_ovf;
            oct_next   = eff_oct;
            skip_next  = eff_skip;
            start_next = 1'b0;
            if (end_of_text)
            begin
                if (!eff_skip)
                begin
                    push     = 1'b1;
                    cmd.term = !cls_bad;
                end
                skip_next  = 1'b0;
                len_next   = '0;
                ovf_next   = 1'b0;
                start_next = 1'b1;
            end
            else if (eff_skip)
            begin
                skip_next = 1'b1;
            end
            else if (is_space)
            begin
                if (!tok_empty)
                begin
                    push      = (cls_cmd.kind != CMD_NONE);
                    oct_next  = cls_oct;
                    skip_next = cls_bad;
                    len_next  = '0;
                    ovf_next  = 1'b0;
                end
            end
            else if (eff_len < LEN_W'(TOKEN_CHARS))
            begin
                char_wr  = 1'b1;
                len_next = eff_len + LEN_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            oct_reg   <= '0;
            skip_reg  <= 1'b0;
            start_reg <= 1'b1;
        end
        else
        begin
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            oct_reg   <= oct_next;
            skip_reg  <= skip_next;
            start_reg <= start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_wr)
            chars_reg[eff_len[IDX_W-1:0]] <= char_code;
    end

endmodule

// ===== rtl/nttseq_queue.sv =====
// ----------------------------------------------------------------------------
// nttseq_queue
// Small command FIFO between the token front end and the result back end.
// ----------------------------------------------------------------------------
module nttseq_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  nttseq_pkg::cmd_t push_cmd,
    input  logic             pop,
    output nttseq_pkg::cmd_t head_cmd,
    output logic             full,
    output logic             empty
);
    import nttseq_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        if (pop)
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== rtl/nttseq_back.sv =====
// ----------------------------------------------------------------------------
// nttseq_back
// Expands queued commands into tone, gap, silence, error and terminator
// results through an output register, one per cycle unless out_ready stalls it.
// ----------------------------------------------------------------------------
`include "note_text_to_tone_sequencer_macros.svh"

module nttseq_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  nttseq_pkg::cfg_t    cfg,
    input  nttseq_pkg::cmd_t    head_cmd,
    input  logic                queue_empty,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output nttseq_pkg::result_t out_result
);
    import nttseq_pkg::*;

    cmd_t       cur_reg;
    logic       cur_valid_reg, cur_valid_next;
    logic [1:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;
    result_t    res;
    logic       out_free;
    logic       advance;
    logic [1:0] nsteps;
    logic       last_step;

    assign out_free  = !out_valid_reg || out_ready;
    assign advance   = cur_valid_reg && out_free;
    assign last_step = (step_reg == nsteps - 2'd1);
    assign pop       = !queue_empty && (!cur_valid_reg || (advance && last_step));

    always_comb
    begin
        res.is_last     = 1'b1;
        res.is_error    = 1'b0;
        res.key_number  = '0;
        res.duration_ms = '0;
        res.freq_hz     = '0;
        unique case (cur_reg.kind)
            CMD_NOTE:
            begin
                nsteps = 2'd2 + {1'b0, cur_reg.term};
                if (step_reg == 2'd0)
                begin
                    res.is_last     = 1'b0;
                    res.key_number  = cur_reg.key;
                    res.freq_hz     = key_freq(cur_reg.key);
                    res.duration_ms = DUR_W'(cfg.tone_ms);
                end
                else if (step_reg == 2'd1)
                begin
                    res.is_last     = 1'b0;
                    res.duration_ms = DUR_W'(cfg.gap_ms);
                end
            end
            CMD_PAUSE:
            begin
                nsteps = 2'd1 + {1'b0, cur_reg.term};
                if (step_reg == 2'd0)
                begin
                    res.is_last     = 1'b0;
                    res.duration_ms = DUR_W'(cfg.pause_unit_ms) << cur_reg.pause_shift;
                end
            end
            CMD_ERROR:
            begin
                nsteps       = 2'd1;
                res.is_error = 1'b1;
            end
            default:
            begin
                nsteps = 2'd1;
            end
        endcase
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            cur_valid_next = 1'b1;
            step_next      = 2'd0;
        end
        else if (advance && last_step)
        begin
            cur_valid_next = 1'b0;
        end
        else if (advance)
        begin
            step_next = step_reg + 2'd1;
        end
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head_cmd;
        if (advance)
            out_reg <= res;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    `NTTSEQ_ASSERT_IMP(a_step_in_range, cur_valid_reg, step_reg < nsteps, "step past command end")
    `NTTSEQ_ASSERT_IMP(a_pop_nonempty, pop, !queue_empty, "pop from empty queue")
    `NTTSEQ_ASSERT_IMP(a_tone_not_last, out_valid_reg && out_reg.key_number != '0,
        out_reg.freq_hz != '0 && !out_reg.is_last && !out_reg.is_error, "bad tone result")
    `NTTSEQ_ASSERT_NXT(a_gap_follows_tone, advance && cur_reg.kind == CMD_NOTE && step_reg == 2'd0,
        cur_valid_reg && step_reg == 2'd1, "gap does not follow tone")

endmodule

// ===== rtl/note_text_to_tone_sequencer.sv =====
// A token's results pass the command queue, the current-command register and the
// output register after the byte closing the token. Throughput: 1 text byte per
// cycle while the queue is not full; the back end gives 1 result per cycle unless
// m_axis_tready stalls it, up to 3 per token, and the 4-entry command queue absorbs
// the difference before ready drops. Reset (rst_n, async, low): control state
// cleared, octave 0, text start pending, config to 500/50/250 ms; no clearing pass.
// ----------------------------------------------------------------------------
// note_text_to_tone_sequencer
// Turns a space-separated note text into a stream of tone items.
// ----------------------------------------------------------------------------
module note_text_to_tone_sequencer
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [7:0] char_code, [11:8] start_octave, [15:12] zero
    input  logic [nttseq_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                                 s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [12:0] freq_hz, [26:13] duration_ms, [33:27] key_number, [39:34] zero
    output logic [nttseq_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [0] is_error
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [nttseq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nttseq_pkg::MS_W-1:0]          cfg_data
);
    import nttseq_pkg::*;

    cfg_t    cfg_reg;
    cmd_t    push_cmd, head_cmd;
    logic    push, pop, q_full, q_empty;
    result_t res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tone_ms       <= TONE_MS_RST;
            cfg_reg.gap_ms        <= GAP_MS_RST;
            cfg_reg.pause_unit_ms <= PAUSE_UNIT_MS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TONE_MS:       cfg_reg.tone_ms       <= cfg_data;
                CFG_GAP_MS:        cfg_reg.gap_ms        <= cfg_data;
                CFG_PAUSE_UNIT_MS: cfg_reg.pause_unit_ms <= cfg_data;
                default:           ;
            endcase
        end
    end

    nttseq_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .char_code    (s_axis_tdata[7:0]),
        .end_of_text  (s_axis_tlast),
        .start_octave (s_axis_tdata[11:8]),
        .queue_full   (q_full),
        .push         (push),
        .cmd          (push_cmd)
    );

    nttseq_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    nttseq_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head_cmd    (head_cmd),
        .queue_empty (q_empty),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_result  (res)
    );

    assign m_axis_tdata = {6'b000000, res.key_number, res.duration_ms, res.freq_hz};
    assign m_axis_tuser = res.is_error;
    assign m_axis_tlast = res.is_last;

endmodule
